FILE: hdl/assert_macros.svh
// Assertion macros shared by the decompressor RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("assertion failed: expr");

// Checks that a condition is followed by a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rstn, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (conseq)) \
        else $error("assertion failed: cond then conseq");

`endif

FILE: hdl/xld_pkg.sv
// Shared types, constants and helpers of the Xpress LZ77 decompressor.
// No dependencies; used by every module of the block.
`default_nettype none

package xld_pkg;

    localparam int WINDOW_BYTES = 8192;
    localparam int WIN_W        = $clog2(WINDOW_BYTES);
    localparam int MAX_OUTPUT   = 65536;
    localparam int DRAIN_BURST  = 64;
    localparam int BURST_W      = $clog2(DRAIN_BURST + 1);
    localparam int CNT_W        = 17;
    localparam int FIFO_DEPTH   = 2;

    // Input item kinds.
    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_STOP   = 2'd2;

    // Parser phases, one-hot.
    typedef enum logic [10:0] {
        PH_FLAG0    = 11'b00000000001,
        PH_FLAG1    = 11'b00000000010,
        PH_FLAG2    = 11'b00000000100,
        PH_FLAG3    = 11'b00000001000,
        PH_ITEM     = 11'b00000010000,
        PH_TOK_HI   = 11'b00000100000,
        PH_NIB      = 11'b00001000000,
        PH_EXT8     = 11'b00010000000,
        PH_EXT16_LO = 11'b00100000000,
        PH_EXT16_HI = 11'b01000000000,
        PH_END      = 11'b10000000000
    } phase_t;

    // Input item as it travels from the front to the back.
    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;

    // One result item.
    typedef struct packed {
        logic [7:0]       out_byte;
        logic             has_byte;
        logic             copy_pending;
        logic             end_of_run;
        logic             block_done;
        logic [1:0]       status;
        logic [CNT_W-1:0] out_count;
    } result_t;

    // Match length, or zero when the match reaches before the block start.
    function automatic logic [CNT_W-1:0] start_len(input logic [12:0] off,
                                                   input logic [CNT_W-1:0] pc,
                                                   input logic [CNT_W-1:0] len);
        logic [CNT_W-1:0] res;
        res = ({4'd0, off} >= pc) ? '0 : len;
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/xld_front.sv
// Front end: accepts input transactions and queues them for the decoder.
// Depends on xld_pkg.
`default_nettype none

module xld_front (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 in_valid,
    output logic                in_ready,
    input  xld_pkg::item_t      in_item,
    output logic                q_valid,
    input  wire                 q_pop,
    output xld_pkg::item_t      q_item
);

    localparam int PTR_W = $clog2(xld_pkg::FIFO_DEPTH);

    xld_pkg::item_t       mem_reg [xld_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]       count_reg,  count_next;
    logic                 push;
    logic                 pop;

    assign in_ready = (count_reg != xld_pkg::FIFO_DEPTH[PTR_W:0]);
    assign q_valid  = (count_reg != '0);
    assign q_item   = mem_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_pop && q_valid;

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + {{PTR_W{1'b0}}, push} - {{PTR_W{1'b0}}, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/xld_back.sv
// Back end: parses compressed bytes, runs match copies out of the history
// memory and holds the result register. Depends on xld_pkg, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module xld_back (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire  [xld_pkg::CNT_W-1:0]        eff_limit,
    input  wire                              q_valid,
    output logic                             q_pop,
    input  xld_pkg::item_t                   q_item,
    output logic                             res_valid,
    input  wire                              res_ready,
    output xld_pkg::result_t                 res_out
);

    localparam int WIN_W = xld_pkg::WIN_W;
    localparam int CW    = xld_pkg::CNT_W;
    localparam int BW    = xld_pkg::BURST_W;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_READ  = 3'b010,
        ST_WRITE = 3'b100
    } bstate_t;

    bstate_t            st_reg,   st_next;
    xld_pkg::phase_t    ph_reg,   ph_next;
    logic [31:0]        fw_reg,   fw_next;
    logic [5:0]         fl_reg,   fl_next;
    logic [7:0]         hold_reg, hold_next;
    logic [3:0]         nib_reg,  nib_next;
    logic               nibv_reg, nibv_next;
    logic [12:0]        off_reg,  off_next;
    logic [CW-1:0]      rem_reg,  rem_next;
    logic [CW-1:0]      pc_reg,   pc_next;
    logic               stop_reg, stop_next;
    logic [BW-1:0]      bcnt_reg, bcnt_next;
    logic               valid_reg, valid_next;
    xld_pkg::result_t   res_reg,  res_next;

    logic [7:0]         hist_mem [xld_pkg::WINDOW_BYTES];
    logic [7:0]         rdata_reg;
    logic               mem_we;
    logic               mem_re;
    logic [WIN_W-1:0]   waddr;
    logic [WIN_W-1:0]   raddr;
    logic [7:0]         wdata;

    logic               out_free;
    logic               clr;
    logic               bit_flag;
    logic               run_end;
    logic               blk_done;
    logic [CW-1:0]      src_full;

    assign out_free  = !valid_reg || res_ready;
    assign res_valid = valid_reg;
    assign res_out   = res_reg;

    // Decoder and copy sequencer.
    always_comb begin
        st_next   = st_reg;
        ph_next   = ph_reg;
        fw_next   = fw_reg;
        fl_next   = fl_reg;
        hold_next = hold_reg;
        nib_next  = nib_reg;
        nibv_next = nibv_reg;
        off_next  = off_reg;
        rem_next  = rem_reg;
        pc_next   = pc_reg;
        stop_next = stop_reg;
        bcnt_next = bcnt_reg;
        valid_next = valid_reg && !res_ready;
        res_next  = res_reg;
        q_pop     = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        waddr     = pc_reg[WIN_W-1:0];
        wdata     = rdata_reg;
        src_full  = pc_reg - {4'd0, off_reg} - {{(CW-1){1'b0}}, 1'b1};
        raddr     = src_full[WIN_W-1:0];
        clr       = 1'b0;
        bit_flag  = 1'b0;
        run_end   = 1'b0;
        blk_done  = 1'b0;

        case (st_reg)
            ST_IDLE: begin
                if (q_valid && out_free) begin
                    q_pop      = 1'b1;
                    valid_next = 1'b1;
                    res_next   = '0;
                    res_next.end_of_run = 1'b1;
                    res_next.out_count  = pc_reg;
                    if (q_item.op == xld_pkg::OP_BYTE) begin
                        if (rem_reg != '0) begin
                            // A byte is refused while a copy is pending.
                            res_next.status       = xld_pkg::ST_REJECT;
                            res_next.copy_pending = 1'b1;
                        end else if (stop_reg) begin
                            // Bytes after the limit are swallowed.
                            res_next.status = xld_pkg::ST_STOP;
                            clr = q_item.last_byte;
                        end else begin
                            case (ph_reg)
                                xld_pkg::PH_FLAG1: begin
                                    fw_next[15:8] = q_item.data_byte;
                                    ph_next = xld_pkg::PH_FLAG2;
                                end
                                xld_pkg::PH_FLAG2: begin
                                    fw_next[23:16] = q_item.data_byte;
                                    ph_next = xld_pkg::PH_FLAG3;
                                end
                                xld_pkg::PH_FLAG3: begin
                                    fw_next[31:24] = q_item.data_byte;
                                    fl_next = 6'd32;
                                    ph_next = xld_pkg::PH_ITEM;
                                end
                                xld_pkg::PH_ITEM: begin
                                    fl_next  = {1'b0, fl_reg[4:0] - 5'd1};
                                    bit_flag = fw_reg[fl_next[4:0]];
                                    if (!bit_flag) begin
                                        // Literal byte.
                                        if (pc_reg >= eff_limit) begin
                                            stop_next = 1'b1;
                                            rem_next  = '0;
                                            res_next.status = xld_pkg::ST_STOP;
                                            blk_done = 1'b1;
                                        end else begin
                                            mem_we  = 1'b1;
                                            wdata   = q_item.data_byte;
                                            pc_next = pc_reg + 1'b1;
                                            res_next.has_byte = 1'b1;
                                            res_next.out_byte = q_item.data_byte;
                                            if (pc_next >= eff_limit) begin
                                                stop_next = 1'b1;
                                                rem_next  = '0;
                                                res_next.status = xld_pkg::ST_STOP;
                                                blk_done = 1'b1;
                                            end
                                        end
                                        ph_next = (fl_next == '0) ? xld_pkg::PH_FLAG0
                                                                  : xld_pkg::PH_ITEM;
                                    end else begin
                                        hold_next = q_item.data_byte;
                                        ph_next   = xld_pkg::PH_TOK_HI;
                                    end
                                end
                                xld_pkg::PH_TOK_HI: begin
                                    off_next = {q_item.data_byte, hold_reg[7:3]};
                                    if (hold_reg[2:0] != 3'd7) begin
                                        rem_next = xld_pkg::start_len(off_next, pc_reg,
                                            {{(CW-3){1'b0}}, hold_reg[2:0]} + 17'd3);
                                        ph_next = (fl_reg == '0) ? xld_pkg::PH_FLAG0
                                                                 : xld_pkg::PH_ITEM;
                                    end else if (nibv_reg) begin
                                        // Use the high nibble saved by an earlier match.
                                        nibv_next = 1'b0;
                                        if (nib_reg != 4'd15) begin
                                            rem_next = xld_pkg::start_len(off_next, pc_reg,
                                                {{(CW-4){1'b0}}, nib_reg} + 17'd10);
                                            ph_next = (fl_reg == '0) ? xld_pkg::PH_FLAG0
                                                                     : xld_pkg::PH_ITEM;
                                        end else begin
                                            ph_next = xld_pkg::PH_EXT8;
                                        end
                                    end else begin
                                        ph_next = xld_pkg::PH_NIB;
                                    end
                                end
                                xld_pkg::PH_NIB: begin
                                    nib_next  = q_item.data_byte[7:4];
                                    nibv_next = 1'b1;
                                    if (q_item.data_byte[3:0] != 4'd15) begin
                                        rem_next = xld_pkg::start_len(off_reg, pc_reg,
                                            {{(CW-4){1'b0}}, q_item.data_byte[3:0]} + 17'd10);
                                        ph_next = (fl_reg == '0) ? xld_pkg::PH_FLAG0
                                                                 : xld_pkg::PH_ITEM;
                                    end else begin
                                        ph_next = xld_pkg::PH_EXT8;
                                    end
                                end
                                xld_pkg::PH_EXT8: begin
                                    if (q_item.data_byte != 8'd255) begin
                                        rem_next = xld_pkg::start_len(off_reg, pc_reg,
                                            {{(CW-8){1'b0}}, q_item.data_byte} + 17'd25);
                                        ph_next = (fl_reg == '0) ? xld_pkg::PH_FLAG0
                                                                 : xld_pkg::PH_ITEM;
                                    end else begin
                                        ph_next = xld_pkg::PH_EXT16_LO;
                                    end
                                end
                                xld_pkg::PH_EXT16_LO: begin
                                    hold_next = q_item.data_byte;
                                    ph_next   = xld_pkg::PH_EXT16_HI;
                                end
                                xld_pkg::PH_EXT16_HI: begin
                                    rem_next = xld_pkg::start_len(off_reg, pc_reg,
                                        {1'b0, q_item.data_byte, hold_reg} + 17'd3);
                                    ph_next = (fl_reg == '0) ? xld_pkg::PH_FLAG0
                                                             : xld_pkg::PH_ITEM;
                                end
                                default: begin
                                    // First flag byte; also the idle end phase.
                                    fw_next = {24'd0, q_item.data_byte};
                                    ph_next = xld_pkg::PH_FLAG1;
                                end
                            endcase
                            res_next.copy_pending = (rem_next != '0);
                            res_next.out_count    = pc_next;
                            // Block end on the last compressed byte.
                            if (q_item.last_byte) begin
                                if (stop_next) begin
                                    clr = 1'b1;
                                end else if (rem_next != '0) begin
                                    ph_next = xld_pkg::PH_END;
                                end else begin
                                    blk_done = 1'b1;
                                    clr = 1'b1;
                                end
                            end
                            res_next.block_done = blk_done;
                        end
                    end else if (rem_reg == '0) begin
                        // Drain with nothing pending.
                        res_next.status = stop_reg ? xld_pkg::ST_STOP : xld_pkg::ST_OK;
                    end else begin
                        valid_next = valid_reg && !res_ready;
                        res_next   = res_reg;
                        bcnt_next  = '0;
                        st_next    = ST_READ;
                    end
                end
            end
            ST_READ: begin
                if (out_free) begin
                    if (pc_reg >= eff_limit) begin
                        // Limit already reached: report the stop without a byte.
                        stop_next  = 1'b1;
                        rem_next   = '0;
                        valid_next = 1'b1;
                        res_next   = '0;
                        res_next.status     = xld_pkg::ST_STOP;
                        res_next.end_of_run = 1'b1;
                        res_next.block_done = 1'b1;
                        res_next.out_count  = pc_reg;
                        clr     = (ph_reg == xld_pkg::PH_END);
                        st_next = ST_IDLE;
                    end else begin
                        mem_re  = 1'b1;
                        st_next = ST_WRITE;
                    end
                end
            end
            ST_WRITE: begin
                if (out_free) begin
                    mem_we     = 1'b1;
                    wdata      = rdata_reg;
                    pc_next    = pc_reg + 1'b1;
                    rem_next   = rem_reg - 1'b1;
                    bcnt_next  = bcnt_reg + 1'b1;
                    valid_next = 1'b1;
                    res_next   = '0;
                    res_next.out_byte = rdata_reg;
                    res_next.has_byte = 1'b1;
                    if (pc_next >= eff_limit) begin
                        stop_next = 1'b1;
                        rem_next  = '0;
                        res_next.status     = xld_pkg::ST_STOP;
                        res_next.end_of_run = 1'b1;
                        res_next.block_done = 1'b1;
                        clr     = (ph_reg == xld_pkg::PH_END);
                        st_next = ST_IDLE;
                    end else begin
                        run_end  = (bcnt_next == xld_pkg::DRAIN_BURST[BW-1:0])
                                   || (rem_next == '0);
                        blk_done = (rem_next == '0) && (ph_reg == xld_pkg::PH_END);
                        res_next.end_of_run = run_end;
                        res_next.block_done = blk_done;
                        clr     = blk_done;
                        st_next = run_end ? ST_IDLE : ST_READ;
                    end
                    res_next.copy_pending = (rem_next != '0);
                    res_next.out_count    = pc_next;
                end
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase

        // Start of a new block.
        if (clr) begin
            fw_next   = '0;
            fl_next   = '0;
            ph_next   = xld_pkg::PH_FLAG0;
            hold_next = '0;
            nib_next  = '0;
            nibv_next = 1'b0;
            off_next  = '0;
            rem_next  = '0;
            pc_next   = '0;
            stop_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= ST_IDLE;
            ph_reg    <= xld_pkg::PH_FLAG0;
            fw_reg    <= '0;
            fl_reg    <= '0;
            hold_reg  <= '0;
            nib_reg   <= '0;
            nibv_reg  <= 1'b0;
            off_reg   <= '0;
            rem_reg   <= '0;
            pc_reg    <= '0;
            stop_reg  <= 1'b0;
            bcnt_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            st_reg    <= st_next;
            ph_reg    <= ph_next;
            fw_reg    <= fw_next;
            fl_reg    <= fl_next;
            hold_reg  <= hold_next;
            nib_reg   <= nib_next;
            nibv_reg  <= nibv_next;
            off_reg   <= off_next;
            rem_reg   <= rem_next;
            pc_reg    <= pc_next;
            stop_reg  <= stop_next;
            bcnt_reg  <= bcnt_next;
            valid_reg <= valid_next;
        end
    end

    // Result payload register.
    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    // History memory with registered read.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            hist_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_re) begin
            rdata_reg <= hist_mem[raddr];
        end
    end

    // A copy step is only under way while match bytes remain.
    `ASSERT_ALWAYS(a_copy_has_work, aclk, aresetn, (st_reg == ST_IDLE) || (rem_reg != '0))
    // The burst counter never passes the drain burst size.
    `ASSERT_ALWAYS(a_burst_bound, aclk, aresetn,
        bcnt_reg <= xld_pkg::DRAIN_BURST[BW-1:0])
    // A history read is always followed by its write step.
    `ASSERT_NEXT(a_read_then_write, aclk, aresetn, mem_re, st_reg == ST_WRITE)

endmodule

`default_nettype wire

FILE: hdl/xpress_lz77_decompressor_core.sv
// Top level of the Xpress LZ77 decompressor: stream ports, limit register.
// Depends on xld_pkg, xld_front and xld_back.
//
// Channel | Direction | Handshake                    | Payload
// s_axis  | in        | s_axis_tvalid/s_axis_tready  | tdata byte, tuser op, tlast last
// m_axis  | out       | m_axis_tvalid/m_axis_tready  | tdata byte/flags/count, tuser, tlast
// cfg     | in        | cfg_wr_en                    | cfg_wr_data output limit
//
// A compressed byte leaves the queue and gives one result, presented in the
// cycle after. A drain transaction leaves the queue, then copies up to 64
// pending match bytes, each by a registered history read before its write.
// A copied byte's result is registered at its write step.
// A held result stalls the decoder; the two-entry queue then stalls the input.
// Reset is synchronous and active low; the history is not cleared.
`default_nettype none

module xpress_lz77_decompressor_core (
    input  wire         aclk,
    input  wire         aresetn,
    // Input stream.
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire         s_axis_tuser,   // [0] op
    input  wire         s_axis_tlast,   // last_byte
    // Result stream.
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] out_byte, [8] copy_pending,
                                        // [9] block_done, [26:10] out_count, zero above
    output logic [2:0]  m_axis_tuser,   // [0] has_byte, [2:1] status
    output logic        m_axis_tlast,   // end_of_run
    // Configuration.
    input  wire         cfg_wr_en,
    input  wire  [16:0] cfg_wr_data
);

    localparam int CW = xld_pkg::CNT_W;

    logic [CW-1:0]      limit_reg;
    logic [CW-1:0]      eff_limit;
    xld_pkg::item_t     in_item;
    xld_pkg::item_t     q_item;
    logic               q_valid;
    logic               q_pop;
    xld_pkg::result_t   res;

    // Output limit register, clamped to the largest block size.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= xld_pkg::MAX_OUTPUT[CW-1:0];
        end else if (cfg_wr_en) begin
            limit_reg <= cfg_wr_data;
        end
    end

    assign eff_limit = (limit_reg > xld_pkg::MAX_OUTPUT[CW-1:0])
                       ? xld_pkg::MAX_OUTPUT[CW-1:0] : limit_reg;

    assign in_item.op        = s_axis_tuser;
    assign in_item.data_byte = s_axis_tdata;
    assign in_item.last_byte = s_axis_tlast;

    xld_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item)
    );

    xld_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .eff_limit (eff_limit),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res_out   (res)
    );

    // Result packing.
    assign m_axis_tdata = {5'd0, res.out_count, res.block_done, res.copy_pending,
                           res.out_byte};
    assign m_axis_tuser = {res.status, res.has_byte};
    assign m_axis_tlast = res.end_of_run;

endmodule

`default_nettype wire
